@@ rtl/sled_pkg.sv @@
// ============================================================================
// sled_pkg
// Shared types, constants and color functions of the status LED color block
// ============================================================================
package sled_pkg;

    localparam int FAULT_SOURCES = 3;
    localparam int DIV_STEPS     = 32;
    localparam int DEN_W         = 17;

    // safety modes
    localparam logic [1:0] MODE_PANIC = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;
    localparam logic [1:0] MODE_OK    = 2'd3;

    // configuration register indexes
    localparam logic [3:0] REG_CALM_SWEEP   = 4'd0;
    localparam logic [3:0] REG_SETTLE_SWEEP = 4'd1;
    localparam logic [3:0] REG_SLOW_BLINK   = 4'd2;
    localparam logic [3:0] REG_HEARTBEAT    = 4'd3;
    localparam logic [3:0] REG_PANIC_PHASE  = 4'd4;
    localparam logic [3:0] REG_FAULT_COLOR0 = 4'd5;
    localparam logic [3:0] REG_FAULT_COLOR1 = 4'd6;
    localparam logic [3:0] REG_FAULT_COLOR2 = 4'd7;

    // item traveling down the pipeline
    typedef struct packed {
        logic [1:0]       mode;
        logic             usb;
        logic             sweep;      // clear mode still in its sweep
        logic             full;       // ready mode with a zero-length sweep
        logic [7:0]       sum_r;
        logic [7:0]       sum_g;
        logic [7:0]       sum_b;
        logic [31:0]      num;        // dividend, turns into the quotient
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } pipe_t;

    // x / 255 for x below 65280, by reciprocal
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] p;
        begin
            p = 32'(x) * 32'd32897;
            div255 = p[30:23];
        end
    endfunction

    // x / 50 for x below 12800, by reciprocal
    function automatic logic [7:0] div50(input logic [15:0] x);
        logic [31:0] p;
        begin
            p = 32'(x) * 32'd20972;
            div50 = p[27:20];
        end
    endfunction

    // t * k / 255 with an 8-bit position
    function automatic logic [7:0] scale(input logic [7:0] t, input logic [7:0] k);
        begin
            scale = div255(16'(t) * 16'(k));
        end
    endfunction

    // breathing blue level for a phase of 0 to 99
    function automatic logic [7:0] breath_b(input logic [6:0] phase);
        logic [7:0] bv;
        begin
            if (phase < 7'd50)
                bv = div50(16'(phase) * 16'd255);
            else
                bv = div50(16'(7'd100 - phase) * 16'd255);
            breath_b = 8'd60 + scale(bv, 8'd140);
        end
    endfunction

endpackage

@@ rtl/status_led_color_generator_top.sv @@
// ============================================================================
// status_led_color_generator_top
// Pipelined RGB color generator for a status LED
// ============================================================================
// One input item (mode, usb, tick, progress counts, fault mask) on the s_axis
// group gives one color item on the m_axis group. Registers are written over
// the cfg channel, which is always ready; write them only while idle.
// The datapath is an operand stage, a 32-stage restoring divider that
// delivers quotient and remainder (all sweeps and tick periods share it), and
// a color stage feeding the output register. One item is accepted every cycle
// while the output is taken. When the receiver stalls the whole pipeline
// holds in place and s_tready drops; nothing is lost or repeated. Reset
// empties the pipeline and loads the registers with their reset values
// (sweeps 50 and 15, blink 100, heartbeat 200, panic phase 25, fault colors
// red, green, blue).
// ============================================================================
module status_led_color_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // safety_mode[1:0] usb_present[2] tick_count[34:3] calm_progress[50:35]
    // settle_progress[66:51] fault_active[69:67] zero[71:70]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // green[7:0] red[15:8] blue[23:16]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int N = sled_pkg::DIV_STEPS;
    localparam int DW = sled_pkg::DEN_W;

    logic [15:0] calm_ticks_reg, settle_ticks_reg, blink_ticks_reg;
    logic [15:0] heart_ticks_reg, panic_ticks_reg;
    logic [23:0] color0_reg, color1_reg, color2_reg;

    logic                  adv;
    sled_pkg::pipe_t       op_next, op_reg;
    logic                  op_vld_reg;
    sled_pkg::pipe_t       div_next [N];
    sled_pkg::pipe_t       div_reg  [N];
    logic [N-1:0]          div_vld_reg;
    logic [23:0]           out_next, out_reg;
    logic                  out_vld_reg;
    logic [7:0]            breath_b_tab [100];
    logic [7:0]            breath_g_tab [100];

    assign adv       = !out_vld_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm_ticks_reg   <= 16'd50;
            settle_ticks_reg <= 16'd15;
            blink_ticks_reg  <= 16'd100;
            heart_ticks_reg  <= 16'd200;
            panic_ticks_reg  <= 16'd25;
            color0_reg       <= 24'hFF0000;
            color1_reg       <= 24'h00FF00;
            color2_reg       <= 24'h0000FF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sled_pkg::REG_CALM_SWEEP:   calm_ticks_reg   <= cfg_data[15:0];
                sled_pkg::REG_SETTLE_SWEEP: settle_ticks_reg <= cfg_data[15:0];
                sled_pkg::REG_SLOW_BLINK:   blink_ticks_reg  <= cfg_data[15:0];
                sled_pkg::REG_HEARTBEAT:    heart_ticks_reg  <= cfg_data[15:0];
                sled_pkg::REG_PANIC_PHASE:  panic_ticks_reg  <= cfg_data[15:0];
                sled_pkg::REG_FAULT_COLOR0: color0_reg       <= cfg_data;
                sled_pkg::REG_FAULT_COLOR1: color1_reg       <= cfg_data;
                sled_pkg::REG_FAULT_COLOR2: color2_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand stage: pick dividend and divisor, sum fault colors
    always_comb
    begin
        logic [1:0]  mode;
        logic [31:0] tick;
        logic [15:0] calm, settle, half, per;
        logic [2:0]  faults;
        logic [9:0]  sr, sg, sb;
        logic [23:0] colors [3];
        mode   = s_tdata[1:0];
        tick   = s_tdata[34:3];
        calm   = s_tdata[50:35];
        settle = s_tdata[66:51];
        faults = s_tdata[69:67];
        colors[0] = color0_reg;
        colors[1] = color1_reg;
        colors[2] = color2_reg;
        sr = '0;
        sg = '0;
        sb = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (i < sled_pkg::FAULT_SOURCES && faults[i])
            begin
                sr = sr + 10'(colors[i][23:16]);
                sg = sg + 10'(colors[i][15:8]);
                sb = sb + 10'(colors[i][7:0]);
            end
        end
        op_next       = '0;
        op_next.mode  = mode;
        op_next.usb   = s_tdata[2];
        op_next.sum_r = (sr > 10'd255) ? 8'd255 : sr[7:0];
        op_next.sum_g = (sg > 10'd255) ? 8'd255 : sg[7:0];
        op_next.sum_b = (sb > 10'd255) ? 8'd255 : sb[7:0];
        half = (panic_ticks_reg == 16'd0) ? 16'd1 : panic_ticks_reg;
        per  = s_tdata[2] ? heart_ticks_reg : blink_ticks_reg;
        case (mode)
            sled_pkg::MODE_PANIC:
            begin
                op_next.num = tick;
                op_next.den = {half, 1'b0};
            end
            sled_pkg::MODE_CLEAR:
            begin
                if (calm < calm_ticks_reg)
                begin
                    op_next.sweep = 1'b1;
                    op_next.num   = 32'({calm, 8'd0} - 24'(calm));
                    op_next.den   = DW'(calm_ticks_reg);
                end
                else
                begin
                    op_next.num = tick;
                    op_next.den = DW'(100);
                end
            end
            sled_pkg::MODE_READY:
            begin
                op_next.full = (settle_ticks_reg == 16'd0);
                op_next.num  = 32'({settle, 8'd0} - 24'(settle));
                op_next.den  = op_next.full ? DW'(1) : DW'(settle_ticks_reg);
            end
            default:
            begin
                op_next.num = tick;
                op_next.den = (per == 16'd0) ? DW'(1) : DW'(per);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_vld_reg <= 1'b0;
        else if (adv)
            op_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            op_reg <= op_next;
    end

    // divider: one quotient bit per stage
    for (genvar k = 0; k < N; k++)
    begin : g_div
        sled_pkg::pipe_t src;
        logic            src_vld;
        logic [DW:0]     trial;
        if (k == 0)
        begin : g_first
            assign src     = op_reg;
            assign src_vld = op_vld_reg;
        end
        else
        begin : g_rest
            assign src     = div_reg[k-1];
            assign src_vld = div_vld_reg[k-1];
        end

        always_comb
        begin
            div_next[k] = src;
            trial = {src.rem, src.num[31]};
            if (trial >= {1'b0, src.den})
            begin
                div_next[k].rem = DW'(trial - {1'b0, src.den});
                div_next[k].num = {src.num[30:0], 1'b1};
            end
            else
            begin
                div_next[k].rem = trial[DW-1:0];
                div_next[k].num = {src.num[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_vld_reg[k] <= 1'b0;
            else if (adv)
                div_vld_reg[k] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[k] <= div_next[k];
        end
    end

    // constant breathing levels, blue and green, by phase
    for (genvar j = 0; j < 100; j++)
    begin : g_breath
        assign breath_b_tab[j] = sled_pkg::breath_b(7'(j));
        assign breath_g_tab[j] = sled_pkg::scale(sled_pkg::breath_b(7'(j)), 8'd80);
    end

    // color stage
    always_comb
    begin
        sled_pkg::pipe_t d;
        logic [7:0] t, g, r, b;
        d = div_reg[N-1];
        t = (d.full || d.num > 32'd255) ? 8'd255 : d.num[7:0];
        g = '0;
        r = '0;
        b = '0;
        case (d.mode)
            sled_pkg::MODE_PANIC:
            begin
                if (d.rem >= (d.den >> 1) && (d.sum_r | d.sum_g | d.sum_b) != 8'd0)
                begin
                    g = d.sum_g;
                    r = d.sum_r;
                    b = d.sum_b;
                end
                else
                begin
                    g = 8'd20;
                    r = 8'd220;
                    b = 8'd60;
                end
            end
            sled_pkg::MODE_CLEAR:
            begin
                if (d.sweep)
                begin
                    r = sled_pkg::scale(8'd255 - t, 8'd200);
                    g = sled_pkg::scale(t, 8'd80);
                    b = 8'd200;
                end
                else
                begin
                    b = breath_b_tab[d.rem[6:0]];
                    g = breath_g_tab[d.rem[6:0]];
                end
            end
            sled_pkg::MODE_READY:
            begin
                g = 8'd80 + sled_pkg::scale(t, 8'd120);
                r = sled_pkg::scale(t, 8'd80);
                b = sled_pkg::scale(8'd255 - t, 8'd200);
            end
            default:
            begin
                if (d.usb)
                    g = (d.rem < DW'(4)) ? 8'd100 : 8'd50;
                else if (d.rem < (d.den >> 1))
                begin
                    g = 8'd180;
                    r = 8'd220;
                end
            end
        endcase
        out_next = {b, r, g};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= div_vld_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

endmodule

@@ rtl/status_led_color_generator_checker.sv @@
// ============================================================================
// status_led_color_generator_checker
// Port-level checks of the status LED color generator
// ============================================================================
module status_led_color_generator_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // a stalled output blocks the input
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // an empty output lets items in
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // config writes never wait
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind status_led_color_generator_top status_led_color_generator_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ tb/tb_status_led_color_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_status_led_color_checker
// Watches the item channels and checks every color against a local prediction
// ============================================================================
// Register writes are mirrored from the cfg channel. Each accepted input item
// is turned into its expected color and queued. Each accepted output item is
// compared field by field with the oldest queued color.
// ============================================================================
module tb_status_led_color_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
    } color_t;

    logic [15:0] calm_len, settle_len, blink_len, beat_len, phase_len;
    logic [23:0] fcolor [3];
    color_t      color_q [$];

    // expected color of one update
    function automatic color_t led_color(input logic [71:0] d);
        logic [1:0]  mode;
        logic        usb;
        logic [31:0] tick;
        logic [15:0] calm, settle;
        logic [2:0]  flt;
        longint      sr, sg, sb, half, t, bv, p, ph;
        color_t      c;
        begin
            mode   = d[1:0];
            usb    = d[2];
            tick   = d[34:3];
            calm   = d[50:35];
            settle = d[66:51];
            flt    = d[69:67];
            c      = '0;
            sr = 0; sg = 0; sb = 0;
            case (mode)
                sled_pkg::MODE_PANIC:
                begin
                    half = longint'((phase_len == 16'd0) ? 16'd1 : phase_len);
                    for (int i = 0; i < sled_pkg::FAULT_SOURCES; i++)
                    begin
                        if (flt[i])
                        begin
                            sr += longint'(fcolor[i][23:16]);
                            sg += longint'(fcolor[i][15:8]);
                            sb += longint'(fcolor[i][7:0]);
                        end
                    end
                    if (sr > 255) sr = 255;
                    if (sg > 255) sg = 255;
                    if (sb > 255) sb = 255;
                    if ((longint'(tick) % (half * 2)) >= half && (sr | sg | sb) != 0)
                    begin
                        c.green = 8'(sg); c.red = 8'(sr); c.blue = 8'(sb);
                    end
                    else
                    begin
                        c.green = 8'd20; c.red = 8'd220; c.blue = 8'd60;
                    end
                end
                sled_pkg::MODE_CLEAR:
                begin
                    if (calm < calm_len)
                    begin
                        t = longint'(calm) * 255 / longint'(calm_len);
                        c.red   = 8'((255 - t) * 200 / 255);
                        c.green = 8'(t * 80 / 255);
                        c.blue  = 8'd200;
                    end
                    else
                    begin
                        ph = longint'(tick) % 100;
                        bv = (ph < 50) ? ph * 255 / 50 : (100 - ph) * 255 / 50;
                        sb = 60 + bv * 140 / 255;
                        c.blue  = 8'(sb);
                        c.green = 8'(sb * 80 / 255);
                    end
                end
                sled_pkg::MODE_READY:
                begin
                    if (settle_len == 16'd0)
                        t = 255;
                    else
                    begin
                        t = longint'(settle) * 255 / longint'(settle_len);
                        if (t > 255) t = 255;
                    end
                    c.green = 8'(80 + t * 120 / 255);
                    c.red   = 8'(t * 80 / 255);
                    c.blue  = 8'((255 - t) * 200 / 255);
                end
                default:
                begin
                    if (!usb)
                    begin
                        p = longint'((blink_len == 16'd0) ? 16'd1 : blink_len);
                        if ((longint'(tick) % p) < (p / 2))
                        begin
                            c.green = 8'd180; c.red = 8'd220;
                        end
                    end
                    else
                    begin
                        p = longint'((beat_len == 16'd0) ? 16'd1 : beat_len);
                        c.green = ((longint'(tick) % p) < 4) ? 8'd100 : 8'd50;
                    end
                end
            endcase
            return c;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        color_t want, got;
        if (!rst_n)
        begin
            calm_len   <= 16'd50;
            settle_len <= 16'd15;
            blink_len  <= 16'd100;
            beat_len   <= 16'd200;
            phase_len  <= 16'd25;
            fcolor[0]  <= 24'hFF0000;
            fcolor[1]  <= 24'h00FF00;
            fcolor[2]  <= 24'h0000FF;
            errors     <= 0;
            pending    <= 0;
            color_q.delete();
        end
        else
        begin
            // register mirror
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sled_pkg::REG_CALM_SWEEP:   calm_len   <= cfg_data[15:0];
                    sled_pkg::REG_SETTLE_SWEEP: settle_len <= cfg_data[15:0];
                    sled_pkg::REG_SLOW_BLINK:   blink_len  <= cfg_data[15:0];
                    sled_pkg::REG_HEARTBEAT:    beat_len   <= cfg_data[15:0];
                    sled_pkg::REG_PANIC_PHASE:  phase_len  <= cfg_data[15:0];
                    sled_pkg::REG_FAULT_COLOR0: fcolor[0]  <= cfg_data;
                    sled_pkg::REG_FAULT_COLOR1: fcolor[1]  <= cfg_data;
                    sled_pkg::REG_FAULT_COLOR2: fcolor[2]  <= cfg_data;
                    default: ;
                endcase
            end
            // predict accepted update
            if (s_tvalid && s_tready)
                color_q.push_back(led_color(s_tdata));
            // compare accepted color
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (color_q.size() == 0)
                begin
                    $display("%0t: unexpected color item, expected none, actual %h",
                             $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = color_q.pop_front();
                    if (got.green !== want.green || got.red !== want.red ||
                        got.blue !== want.blue)
                    begin
                        $display({"%0t: color mismatch, expected g%0d r%0d b%0d,",
                                  " actual g%0d r%0d b%0d"},
                                 $time, want.green, want.red, want.blue,
                                 got.green, got.red, got.blue);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= color_q.size();
        end
    end

endmodule

@@ tb/tb_status_led_color_generator_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_status_led_color_generator_top
// Stimulus and verdict for the status LED color generator
// ============================================================================
// Runs several register settings, extremes among them. Each phase sends a
// directed set then random updates, gapped on input and output save with the
// largest values. The checker beside the block predicts and compares every color.
// ============================================================================
module tb_status_led_color_generator_top;

    localparam int LATENCY = 34;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;
    int          quiet_cycles;
    bit          calm_out;
    bit          timed_out;

    status_led_color_generator_top uut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tb_status_led_color_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver stalls, none while calm_out is set
    always @(negedge clk)
        m_tready <= calm_out ? 1'b1 : ($urandom_range(99) >= 9);

    // watchdog on accept-free cycles
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one update, holding valid until accepted
    task automatic send_update(input logic [1:0] mode, input logic usb,
                               input logic [31:0] tick, input logic [15:0] calm,
                               input logic [15:0] settle, input logic [2:0] flt,
                               input bit gaps);
        begin
            while (gaps && $urandom_range(99) < 9)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {2'b00, flt, settle, calm, tick, usb, mode};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [23:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // wait until every color has arrived
    task automatic drain;
        begin
            s_tvalid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (LATENCY + 4) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] rand_len();
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 6));
            1: return 16'($urandom_range(0, 300));
            2: return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    // directed and random updates of one phase
    task automatic run_phase(input int count, input bit gaps);
        logic [31:0] tk;
        begin
            send_update(sled_pkg::MODE_PANIC, 1'b0, 32'd0, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_PANIC, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                        3'd7, gaps);
            send_update(sled_pkg::MODE_PANIC, 1'b0, 32'd25, 16'd0, 16'd0, 3'd1, gaps);
            send_update(sled_pkg::MODE_PANIC, 1'b0, 32'd26, 16'd0, 16'd0, 3'd6, gaps);
            send_update(sled_pkg::MODE_CLEAR, 1'b0, 32'd0, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_CLEAR, 1'b1, 32'd50, 16'd49, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_CLEAR, 1'b0, 32'd99, 16'hFFFF, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_CLEAR, 1'b0, 32'hFFFF_FFFF, 16'd50, 16'd0,
                        3'd0, gaps);
            send_update(sled_pkg::MODE_READY, 1'b0, 32'd0, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_READY, 1'b0, 32'd0, 16'd0, 16'd15, 3'd0, gaps);
            send_update(sled_pkg::MODE_READY, 1'b1, 32'd0, 16'd0, 16'hFFFF, 3'd7, gaps);
            send_update(sled_pkg::MODE_OK, 1'b0, 32'd0, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_OK, 1'b0, 32'd50, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_OK, 1'b1, 32'd3, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_OK, 1'b1, 32'd4, 16'd0, 16'd0, 3'd0, gaps);
            send_update(sled_pkg::MODE_OK, 1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0, 3'd0, gaps);
            for (int n = 0; n < count; n++)
            begin
                tk = ($urandom_range(1) == 0) ? 32'($urandom_range(0, 1000)) : $urandom;
                send_update(2'($urandom), 1'($urandom), tk,
                            ($urandom_range(1) == 0) ? 16'($urandom_range(0, 400))
                                                     : 16'($urandom),
                            ($urandom_range(1) == 0) ? 16'($urandom_range(0, 300))
                                                     : 16'($urandom),
                            3'($urandom), gaps);
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sled_pkg::REG_CALM_SWEEP;
        cfg_data  = '0;
        calm_out  = 1'b0;
        timed_out = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values
        run_phase(64, 1'b1);

        // smallest values, zero lengths included
        write_reg(sled_pkg::REG_CALM_SWEEP, 24'd0);
        write_reg(sled_pkg::REG_SETTLE_SWEEP, 24'd0);
        write_reg(sled_pkg::REG_SLOW_BLINK, 24'd0);
        write_reg(sled_pkg::REG_HEARTBEAT, 24'd0);
        write_reg(sled_pkg::REG_PANIC_PHASE, 24'd0);
        write_reg(sled_pkg::REG_FAULT_COLOR0, 24'h000000);
        write_reg(sled_pkg::REG_FAULT_COLOR1, 24'h000000);
        write_reg(sled_pkg::REG_FAULT_COLOR2, 24'h000000);
        run_phase(40, 1'b1);

        // largest values, clamped fault sums
        write_reg(sled_pkg::REG_CALM_SWEEP, 24'hFFFF);
        write_reg(sled_pkg::REG_SETTLE_SWEEP, 24'hFFFF);
        write_reg(sled_pkg::REG_SLOW_BLINK, 24'hFFFF);
        write_reg(sled_pkg::REG_HEARTBEAT, 24'hFFFF);
        write_reg(sled_pkg::REG_PANIC_PHASE, 24'hFFFF);
        write_reg(sled_pkg::REG_FAULT_COLOR0, 24'hFFFFFF);
        write_reg(sled_pkg::REG_FAULT_COLOR1, 24'hFFFFFF);
        write_reg(sled_pkg::REG_FAULT_COLOR2, 24'hFFFFFF);
        calm_out = 1'b1;
        run_phase(40, 1'b0);
        calm_out = 1'b0;

        // random settings
        for (int k = 0; k < 4; k++)
        begin
            write_reg(sled_pkg::REG_CALM_SWEEP, 24'(rand_len()));
            write_reg(sled_pkg::REG_SETTLE_SWEEP, 24'(rand_len()));
            write_reg(sled_pkg::REG_SLOW_BLINK, 24'(rand_len()));
            write_reg(sled_pkg::REG_HEARTBEAT, 24'(rand_len()));
            write_reg(sled_pkg::REG_PANIC_PHASE, 24'(rand_len()));
            write_reg(sled_pkg::REG_FAULT_COLOR0, 24'($urandom));
            write_reg(sled_pkg::REG_FAULT_COLOR1, 24'($urandom));
            write_reg(sled_pkg::REG_FAULT_COLOR2, 24'($urandom));
            run_phase(36, 1'b1);
        end

        if (errors == 0 && !timed_out)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
